>>> hdl/srfc_pkg.sv
package srfc_pkg;

  // Frame layout and check constants.
  localparam logic [2:0]  HEADER_BYTES   = 3'd6;
  localparam logic [15:0] CRC_SEED       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'h1021;
  localparam logic [7:0]  HW_FAULT_LIMIT = 8'h20;
  localparam logic [7:0]  STATUS_OK      = 8'h00;

  // Header byte positions.
  localparam logic [2:0] POS_COMMAND  = 3'd0;
  localparam logic [2:0] POS_STATUS   = 3'd1;
  localparam logic [2:0] POS_LEN_LO   = 3'd2;
  localparam logic [2:0] POS_LEN_HI   = 3'd3;
  localparam logic [2:0] POS_CSUM_LO  = 3'd4;
  localparam logic [2:0] POS_CSUM_HI  = 3'd5;

  // Configuration register indexes.
  localparam logic [0:0] CFG_EXPECTED_COMMAND = 1'b0;
  localparam logic [0:0] CFG_PAYLOAD_CAPACITY = 1'b1;

  typedef enum logic [2:0] {
    VERDICT_OK           = 3'd0,
    VERDICT_CRC_BAD      = 3'd1,
    VERDICT_SENSOR_ERROR = 3'd2,
    VERDICT_CMD_MISMATCH = 3'd3,
    VERDICT_TOO_LONG     = 3'd4,
    VERDICT_LINK_FAILURE = 3'd5
  } verdict_t;

  // One queue entry: what a single accepted byte produced.
  typedef struct packed {
    logic       has_payload;
    logic [7:0] payload_byte;
    logic       has_verdict;
    verdict_t   verdict;
    logic [7:0] sensor_code;
    logic       hardware_fault;
  } qentry_t;

  // One result item as seen on the output ports.
  typedef struct packed {
    logic       is_verdict;
    logic [7:0] payload_byte;
    verdict_t   verdict;
    logic [7:0] sensor_code;
    logic       hardware_fault;
    logic       last;
  } item_t;

  // CRC-16/CCITT-FALSE update by one byte, MSB first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> hdl/srfc_front.sv
module srfc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       rx_byte,
  input  logic             link_failure,
  input  logic             cfg_write,
  input  logic [0:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  output logic             entry_push,
  output srfc_pkg::qentry_t entry
);
  import srfc_pkg::*;

  // Configuration registers.
  logic [7:0]  expected_command;
  logic [15:0] payload_capacity;

  // Frame state.
  logic [2:0]  header_position;
  logic [15:0] running_crc;
  logic [15:0] received_checksum;
  logic [7:0]  reply_command;
  logic [7:0]  reply_status;
  logic [15:0] payload_length;
  logic [15:0] payload_remaining;

  logic        in_header;
  logic [7:0]  crc_byte;
  logic [15:0] crc_next;
  logic [15:0] checksum_check;
  logic [15:0] remaining_dec;
  logic        frame_end;
  logic        crc_ok;
  verdict_t    verdict_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_command <= '0;
      payload_capacity <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_EXPECTED_COMMAND: expected_command <= cfg_data[7:0];
        CFG_PAYLOAD_CAPACITY: payload_capacity <= cfg_data;
      endcase
    end
  end

  // CRC input: checksum bytes count as zero.
  assign in_header = (header_position < HEADER_BYTES);
  assign crc_byte  = (in_header && header_position >= POS_CSUM_LO) ? 8'h00 : rx_byte;
  assign crc_next  = crc_feed(running_crc, crc_byte);
  assign remaining_dec = payload_remaining - 16'd1;

  // The frame closes on the last header byte of an empty frame or the last payload byte.
  always_comb begin
    if (in_header) begin
      frame_end      = (header_position == POS_CSUM_HI) && (payload_length == 16'd0);
      checksum_check = {rx_byte, received_checksum[7:0]};
    end else begin
      frame_end      = (remaining_dec == 16'd0);
      checksum_check = received_checksum;
    end
  end

  // Verdict priority: CRC, sensor status, command echo, length.
  assign crc_ok = (crc_next == checksum_check);
  always_comb begin
    priority if (!crc_ok) begin
      verdict_code = VERDICT_CRC_BAD;
    end else if (reply_status != STATUS_OK && reply_status < HW_FAULT_LIMIT) begin
      verdict_code = VERDICT_SENSOR_ERROR;
    end else if (reply_command != expected_command) begin
      verdict_code = VERDICT_CMD_MISMATCH;
    end else if (payload_length > payload_capacity) begin
      verdict_code = VERDICT_TOO_LONG;
    end else begin
      verdict_code = VERDICT_OK;
    end
  end

  // Classify the byte into a queue entry.
  always_comb begin
    entry = '0;
    entry.verdict = VERDICT_OK;
    if (link_failure) begin
      entry.has_verdict = 1'b1;
      entry.verdict     = VERDICT_LINK_FAILURE;
    end else begin
      entry.has_payload  = !in_header;
      entry.payload_byte = in_header ? 8'h00 : rx_byte;
      if (frame_end) begin
        entry.has_verdict    = 1'b1;
        entry.verdict        = verdict_code;
        entry.sensor_code    = reply_status;
        entry.hardware_fault = crc_ok && (reply_status >= HW_FAULT_LIMIT);
      end
    end
  end

  assign entry_push = accept && (entry.has_payload || entry.has_verdict);

  // Frame state update per accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      header_position   <= '0;
      running_crc       <= CRC_SEED;
      received_checksum <= '0;
      reply_command     <= '0;
      reply_status      <= '0;
      payload_length    <= '0;
      payload_remaining <= '0;
    end else if (accept) begin
      if (link_failure || frame_end) begin
        header_position   <= '0;
        running_crc       <= CRC_SEED;
        received_checksum <= '0;
        reply_command     <= '0;
        reply_status      <= '0;
        payload_length    <= '0;
        payload_remaining <= '0;
      end else if (in_header) begin
        running_crc     <= crc_next;
        header_position <= header_position + 3'd1;
        unique case (header_position)
          POS_COMMAND: reply_command <= rx_byte;
          POS_STATUS:  reply_status  <= rx_byte;
          POS_LEN_LO:  payload_length[7:0]  <= rx_byte;
          POS_LEN_HI:  payload_length[15:8] <= rx_byte;
          POS_CSUM_LO: received_checksum[7:0] <= rx_byte;
          POS_CSUM_HI: begin
            received_checksum[15:8] <= rx_byte;
            payload_remaining       <= payload_length;
          end
          default: ;
        endcase
      end else begin
        running_crc       <= crc_next;
        payload_remaining <= remaining_dec;
      end
    end
  end

endmodule

>>> hdl/srfc_queue.sv
module srfc_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  srfc_pkg::qentry_t push_entry,
  input  logic              pop,
  output logic              full,
  output logic              nonempty,
  output srfc_pkg::qentry_t head
);
  import srfc_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

  qentry_t        slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> hdl/srfc_back.sv
module srfc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              entry_valid,
  input  srfc_pkg::qentry_t entry,
  output logic              entry_take,
  input  logic              pop,
  output logic              empty,
  output srfc_pkg::item_t   item
);
  import srfc_pkg::*;

  item_t out_item;
  logic  out_valid;
  item_t pend_item;
  logic  pend_valid;
  item_t payload_item;
  item_t verdict_item;
  logic  load;

  // Expand an entry into its payload and verdict items.
  always_comb begin
    payload_item                = '0;
    payload_item.verdict        = VERDICT_OK;
    payload_item.payload_byte   = entry.payload_byte;
    verdict_item                = '0;
    verdict_item.is_verdict     = 1'b1;
    verdict_item.verdict        = entry.verdict;
    verdict_item.sensor_code    = entry.sensor_code;
    verdict_item.hardware_fault = entry.hardware_fault;
    verdict_item.last           = 1'b1;
  end

  // The output register reloads when it is free or its item is taken.
  assign load       = !out_valid || pop;
  assign entry_take = load && !pend_valid && entry_valid;
  assign empty      = !out_valid;
  assign item       = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (load) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (entry_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= entry.has_payload && entry.has_verdict;
      end else begin
        out_valid  <= 1'b0;
      end
    end
  end

  // Payload of the output and pending registers.
  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_valid) begin
        out_item <= pend_item;
      end else if (entry_valid) begin
        out_item  <= entry.has_payload ? payload_item : verdict_item;
        pend_item <= verdict_item;
      end
    end
  end

endmodule

>>> hdl/sensor_reply_frame_checker.sv
// Sensor reply frame checker. Bytes of a reply frame enter one per transaction on
// push/full: a six-byte header (command, status, length and checksum, both little
// endian) and then the payload. Payload bytes come out as they arrive, and each frame
// ends with one verdict item (last high) after a CRC-16/CCITT-FALSE check with the
// checksum bytes taken as zero. A byte with link_failure set aborts the frame and
// yields a link-failure verdict. The block takes one byte per clock while full is low:
// the CRC update and header decode finish in the front stage, and a small queue carries
// the results to an output register that delivers one item per cycle while the consumer
// pops. The last payload byte yields two items and so holds the output side longer;
// the queue absorbs this, and full rises only when the consumer stalls.
// Configuration writes are taken in any cycle on cfg_valid/cfg_ready; change them
// only between frames.
module sensor_reply_frame_checker #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  // Byte input
  input  logic                push,
  output logic                full,
  input  logic [7:0]          rx_byte,
  input  logic                link_failure,
  // Result output
  output logic                empty,
  input  logic                pop,
  output logic                is_verdict,
  output logic [7:0]          payload_byte,
  output srfc_pkg::verdict_t  verdict,
  output logic [7:0]          sensor_code,
  output logic                hardware_fault,
  output logic                last,
  // Configuration
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import srfc_pkg::*;

  logic    accept;
  logic    entry_push;
  qentry_t entry_in;
  qentry_t entry_head;
  logic    entry_valid;
  logic    entry_take;
  item_t   item;

  assign accept    = push && !full;
  assign cfg_ready = 1'b1;

  srfc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .rx_byte      (rx_byte),
    .link_failure (link_failure),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .entry_push   (entry_push),
    .entry        (entry_in)
  );

  srfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (entry_push),
    .push_entry (entry_in),
    .pop        (entry_take),
    .full       (full),
    .nonempty   (entry_valid),
    .head       (entry_head)
  );

  srfc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .entry_valid (entry_valid),
    .entry       (entry_head),
    .entry_take  (entry_take),
    .pop         (pop),
    .empty       (empty),
    .item        (item)
  );

  // Result fields.
  assign is_verdict     = item.is_verdict;
  assign payload_byte   = item.payload_byte;
  assign verdict        = item.verdict;
  assign sensor_code    = item.sensor_code;
  assign hardware_fault = item.hardware_fault;
  assign last           = item.last;

endmodule
